>>> hdl/tdsd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdsd_pkg: shared types and constants for the two-digit display multiplexer
// Display mode codes, register indexes, field widths and the segment table.
// ----------------------------------------------------------------------------
package tdsd_pkg;

   // Field widths
   localparam int STEP_W  = 8;
   localparam int PERIOD_W = 16;
   localparam int VALUE_W = 8;
   localparam int SEG_W   = 8;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   // Display modes; the unused code behaves as blank
   typedef enum logic [1:0] {
      MODE_NORMAL = 2'd0,
      MODE_SET    = 2'd1,
      MODE_BLANK  = 2'd2,
      MODE_SPARE  = 2'd3
   } mode_type;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_TICK_STEP     = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_UPDATE_PERIOD = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BLINK_PERIOD  = 2'd2;

   // Register reset values
   localparam logic [STEP_W-1:0]   TICK_STEP_RST     = 8'd1;
   localparam logic [PERIOD_W-1:0] UPDATE_PERIOD_RST = 16'd2;
   localparam logic [PERIOD_W-1:0] BLINK_PERIOD_RST  = 16'd100;

   // Largest value that fits on two digits
   localparam logic [VALUE_W-1:0] VALUE_MAX = 8'd99;

   // Seven-segment patterns, bit 0 is segment a
   typedef logic [SEG_W-1:0] seg_array_type [10];
   localparam seg_array_type SEG_TABLE = '{
      8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07, 8'h7F, 8'h6F
   };

   // One result word
   typedef struct packed {
      logic [SEG_W-1:0] segments;
      logic             tens_enable;
      logic             units_enable;
      logic             hidden;
   } rsp_word_type;

endpackage

>>> hdl/tdsd_digit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdsd_digit: value to segment pattern
// Saturates a value to 99, picks its tens or units digit and looks it up.
// ----------------------------------------------------------------------------
module tdsd_digit (
   input  logic [tdsd_pkg::VALUE_W-1:0] value,
   input  logic                         units_sel,
   output logic [tdsd_pkg::SEG_W-1:0]   segments
);
   import tdsd_pkg::*;

   logic [6:0]  sat_value;
   logic [14:0] tens_prod;
   logic [3:0]  tens_digit;
   logic [6:0]  tens_times10;
   logic [3:0]  units_digit;
   logic [3:0]  digit;

   // Clamp to two digits
   assign sat_value = (value > VALUE_MAX) ? VALUE_MAX[6:0] : value[6:0];

   // v / 10 as (v * 205) >> 11, exact for every 7-bit v
   assign tens_prod    = 15'(sat_value) * 15'd205;
   assign tens_digit   = tens_prod[14:11];
   assign tens_times10 = 7'({3'b000, tens_digit} * 7'd10);
   assign units_digit  = 4'(sat_value - tens_times10);

   assign digit    = units_sel ? units_digit : tens_digit;
   assign segments = SEG_TABLE[digit];

endmodule

>>> hdl/two_digit_segment_display_mux.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_digit_segment_display_mux: tick-driven two-digit display multiplexer
// Counts ticks, alternates tens and units digits and handles blink and blank.
// ----------------------------------------------------------------------------
// Each accepted req word is one timer tick and yields exactly one rsp word
// holding the display latches after that tick. A tick is accepted in every
// cycle while req_stall is low: the counter and latch update is one pass of
// logic into the state registers, and the result goes to a two-word output
// buffer (output register plus skid register), so req_stall rises only once
// both hold unread words. The csr port may be written only while no tick is
// in flight.
// ----------------------------------------------------------------------------
module two_digit_segment_display_mux (
   input  logic                            clock,
   input  logic                            reset,
   // configuration
   input  logic                            csr_write_enable,
   input  logic [tdsd_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [tdsd_pkg::CSR_DATA_W-1:0] csr_write_data,
   // tick input
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [1:0]                      req_mode,
   input  logic [tdsd_pkg::VALUE_W-1:0]    req_measured_value,
   input  logic [tdsd_pkg::VALUE_W-1:0]    req_target_value,
   // display output
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [tdsd_pkg::SEG_W-1:0]      rsp_segments,
   output logic                            rsp_tens_enable,
   output logic                            rsp_units_enable,
   output logic                            rsp_hidden
);
   import tdsd_pkg::*;

   // Configuration registers
   logic [STEP_W-1:0]   tick_step_ff;
   logic [PERIOD_W-1:0] update_period_ff;
   logic [PERIOD_W-1:0] blink_period_ff;

   // Display state
   logic [PERIOD_W-1:0] update_count_ff, update_count_in;
   logic [PERIOD_W-1:0] blink_count_ff, blink_count_in;
   logic                next_is_units_ff, next_is_units_in;
   logic                hidden_ff, hidden_in;
   logic [SEG_W-1:0]    segment_ff, segment_in;
   logic                tens_ff, tens_in;
   logic                units_ff, units_in;

   // Output buffer
   rsp_word_type out_word_ff, out_word_in;
   rsp_word_type skid_word_ff, skid_word_in;
   logic         out_valid_ff, out_valid_in;
   logic         skid_valid_ff, skid_valid_in;

   logic                req_accept;
   logic                out_taken;
   mode_type            mode;
   logic [VALUE_W-1:0]  shown_value;
   logic [SEG_W-1:0]    digit_segments;
   logic [PERIOD_W:0]   update_sum;
   logic [PERIOD_W:0]   blink_sum;
   logic                refresh;
   logic                blink_wrap;
   rsp_word_type        new_word;

   assign req_stall  = skid_valid_ff;
   assign req_accept = req_valid && !skid_valid_ff;
   assign out_taken  = out_valid_ff && !rsp_stall;

   assign mode = mode_type'(req_mode);

   // Digit lookup for the value of the current mode
   assign shown_value = (mode == MODE_SET) ? req_target_value : req_measured_value;

   tdsd_digit u_digit (
      .value     (shown_value),
      .units_sel (next_is_units_ff),
      .segments  (digit_segments)
   );

   // Counter sums and period checks
   assign update_sum = {1'b0, update_count_ff} + (PERIOD_W+1)'(tick_step_ff);
   assign blink_sum  = {1'b0, blink_count_ff} + (PERIOD_W+1)'(tick_step_ff);
   assign refresh    = update_sum >= {1'b0, update_period_ff};
   assign blink_wrap = blink_sum >= {1'b0, blink_period_ff};

   // Next display state for one tick
   always_comb begin
      update_count_in  = update_count_ff;
      blink_count_in   = blink_count_ff;
      next_is_units_in = next_is_units_ff;
      hidden_in        = hidden_ff;
      segment_in       = segment_ff;
      tens_in          = tens_ff;
      units_in         = units_ff;
      if (refresh) begin
         update_count_in = '0;
         case (mode)
            MODE_NORMAL, MODE_SET: begin
               if (!hidden_ff) begin
                  tens_in    = !next_is_units_ff;
                  units_in   = next_is_units_ff;
                  segment_in = digit_segments;
               end
               next_is_units_in = !next_is_units_ff;
               if (mode == MODE_SET) begin
                  if (blink_wrap) begin
                     segment_in     = '0;
                     hidden_in      = !hidden_ff;
                     blink_count_in = '0;
                  end else begin
                     blink_count_in = blink_sum[PERIOD_W-1:0];
                  end
               end
            end
            default: begin
               segment_in = '0;
            end
         endcase
      end else begin
         update_count_in = update_sum[PERIOD_W-1:0];
      end
   end

   assign new_word = '{segments:     segment_in,
                       tens_enable:  tens_in,
                       units_enable: units_in,
                       hidden:       hidden_in};

   // Output register and skid register
   always_comb begin
      out_word_in   = out_word_ff;
      out_valid_in  = out_valid_ff && !out_taken;
      skid_word_in  = skid_word_ff;
      skid_valid_in = skid_valid_ff;
      if (!out_valid_ff || out_taken) begin
         if (skid_valid_ff) begin
            out_word_in   = skid_word_ff;
            out_valid_in  = 1'b1;
            skid_valid_in = 1'b0;
         end else if (req_accept) begin
            out_word_in  = new_word;
            out_valid_in = 1'b1;
         end
      end else if (req_accept) begin
         skid_word_in  = new_word;
         skid_valid_in = 1'b1;
      end
   end

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         tick_step_ff     <= TICK_STEP_RST;
         update_period_ff <= UPDATE_PERIOD_RST;
         blink_period_ff  <= BLINK_PERIOD_RST;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_TICK_STEP:     tick_step_ff     <= csr_write_data[STEP_W-1:0];
            CSR_UPDATE_PERIOD: update_period_ff <= csr_write_data[PERIOD_W-1:0];
            CSR_BLINK_PERIOD:  blink_period_ff  <= csr_write_data[PERIOD_W-1:0];
            default: ;
         endcase
      end
   end

   // Display state, updated once per accepted tick
   always_ff @(posedge clock) begin
      if (reset) begin
         update_count_ff  <= '0;
         blink_count_ff   <= '0;
         next_is_units_ff <= 1'b0;
         hidden_ff        <= 1'b0;
         segment_ff       <= '0;
         tens_ff          <= 1'b0;
         units_ff         <= 1'b0;
      end else if (req_accept) begin
         update_count_ff  <= update_count_in;
         blink_count_ff   <= blink_count_in;
         next_is_units_ff <= next_is_units_in;
         hidden_ff        <= hidden_in;
         segment_ff       <= segment_in;
         tens_ff          <= tens_in;
         units_ff         <= units_in;
      end
   end

   // Output buffer registers
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_word_ff  <= out_word_in;
      skid_word_ff <= skid_word_in;
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_segments     = out_word_ff.segments;
   assign rsp_tens_enable  = out_word_ff.tens_enable;
   assign rsp_units_enable = out_word_ff.units_enable;
   assign rsp_hidden       = out_word_ff.hidden;

endmodule
